[sv/pcd_pkg.sv]
// Shared types and constants for the clamped PID duty controller.
// No dependencies; used by pcd_regs and clamped_pid_duty_controller.
package pcd_pkg;

	localparam int SAMPLE_BITS_DEF = 10;
	localparam int GAIN_W          = 24;
	localparam int DUTY_W          = 10;
	localparam int THR_W           = 10;
	localparam int FRAC_BITS       = 16;
	localparam int SUM_W           = 32;
	localparam int IDX_W           = 3;
	localparam int CFG_W           = 24;
	localparam int OUT_W           = ((DUTY_W + 1 + 7) / 8) * 8;

	// register indexes
	localparam logic [IDX_W-1:0] REG_GAIN_P          = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_GAIN_I          = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_GAIN_D          = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_DUTY_CEILING    = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_LEVEL_THRESHOLD = IDX_W'(4);

	// reset values
	localparam logic [GAIN_W-1:0] GAIN_P_RST    = GAIN_W'(65536);
	localparam logic [GAIN_W-1:0] GAIN_I_RST    = GAIN_W'(655);
	localparam logic [GAIN_W-1:0] GAIN_D_RST    = GAIN_W'(0);
	localparam logic [DUTY_W-1:0] CEILING_RST   = DUTY_W'(100);
	localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(622);

	typedef struct packed {
		logic [GAIN_W-1:0] gain_p;
		logic [GAIN_W-1:0] gain_i;
		logic [GAIN_W-1:0] gain_d;
		logic [DUTY_W-1:0] duty_ceiling;
		logic [THR_W-1:0]  level_threshold;
	} pcd_cfg_t;

endpackage

[sv/pcd_regs.sv]
// Configuration register file of the PID duty controller.
// Depends on pcd_pkg for widths, register indexes and reset values.
module pcd_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pcd_pkg::IDX_W-1:0]     cfg_index,
	input  logic [pcd_pkg::CFG_W-1:0]     cfg_data,
	output pcd_pkg::pcd_cfg_t             cfg
);

	pcd_pkg::pcd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p          <= pcd_pkg::GAIN_P_RST;
			cfg_q.gain_i          <= pcd_pkg::GAIN_I_RST;
			cfg_q.gain_d          <= pcd_pkg::GAIN_D_RST;
			cfg_q.duty_ceiling    <= pcd_pkg::CEILING_RST;
			cfg_q.level_threshold <= pcd_pkg::THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pcd_pkg::REG_GAIN_P: begin
					cfg_q.gain_p <= cfg_data[pcd_pkg::GAIN_W-1:0];
				end
				pcd_pkg::REG_GAIN_I: begin
					cfg_q.gain_i <= cfg_data[pcd_pkg::GAIN_W-1:0];
				end
				pcd_pkg::REG_GAIN_D: begin
					cfg_q.gain_d <= cfg_data[pcd_pkg::GAIN_W-1:0];
				end
				pcd_pkg::REG_DUTY_CEILING: begin
					cfg_q.duty_ceiling <= cfg_data[pcd_pkg::DUTY_W-1:0];
				end
				pcd_pkg::REG_LEVEL_THRESHOLD: begin
					cfg_q.level_threshold <= cfg_data[pcd_pkg::THR_W-1:0];
				end
				default: begin
					// unmapped index: write dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/clamped_pid_duty_controller.sv]
// Top level of the clamped PID duty controller: input register, error and
// integral stage, gain multipliers, clamp and output register.
// Depends on pcd_pkg and pcd_regs.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata, each a reference and a
//   feedback converter sample. Every input word yields exactly one output word
//   on m_tvalid/m_tready/m_tdata: the PWM duty and the level flag.
//   Gains, duty ceiling and level threshold are written through
//   cfg_we/cfg_index/cfg_data while the block is idle; unmapped indexes drop.
//   Pipeline: the edge that accepts an input word loads the input register;
//   the word then moves on through the error/integral, product and output
//   registers in that order. Throughput: one word per cycle while m_tready
//   stays high; each stage holds one word and loads when it is empty or the
//   stage after it moves.
//   The only feedback loop is the 32-bit saturating integral add and the
//   previous-error register, both updated together as a word enters the
//   second stage, so words can follow back to back.
//   Stall: when m_tready is low the output word holds; earlier stages keep
//   filling until every stage is full, then s_tready drops.
//   Reset (arst_n low): all stages empty, integral and previous error zero,
//   registers back to their reset values (gains 1.0, ~0.01, 0; ceiling 100;
//   threshold 622).
module clamped_pid_duty_controller #(
	parameter int SAMPLE_BITS = pcd_pkg::SAMPLE_BITS_DEF,
	localparam int IN_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [IN_W-1:0]               s_tdata,   // reference_sample, feedback_sample, zero pad
	// output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pcd_pkg::OUT_W-1:0]     m_tdata,   // duty, level_high, zero pad
	// configuration writes
	input  logic                          cfg_we,
	input  logic [pcd_pkg::IDX_W-1:0]     cfg_index,
	input  logic [pcd_pkg::CFG_W-1:0]     cfg_data
);

	localparam int ERR_W  = SAMPLE_BITS + 1;
	localparam int DEL_W  = SAMPLE_BITS + 2;
	localparam int SUM_W  = pcd_pkg::SUM_W;
	localparam int G_W    = pcd_pkg::GAIN_W + 1;         // gain with a zero sign bit
	localparam int PP_W   = G_W + ERR_W;
	localparam int PI_W   = G_W + SUM_W;
	localparam int PD_W   = G_W + DEL_W;
	localparam int ACC_W  = PI_W + 2;
	localparam int FRAC   = pcd_pkg::FRAC_BITS;
	localparam int DUTY_W = pcd_pkg::DUTY_W;
	localparam int CMP_W  = (SAMPLE_BITS > pcd_pkg::THR_W) ? SAMPLE_BITS : pcd_pkg::THR_W;

	pcd_pkg::pcd_cfg_t cfg;

	pcd_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// ---------------------------------------------------------------
	// Stage flow control: a stage loads when empty or when it moves on.
	// ---------------------------------------------------------------
	logic v_s1, v_s2, v_s3, m_valid_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_out;

	assign rdy_out  = !m_valid_q || m_tready;
	assign rdy_s3   = !v_s3 || rdy_out;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	logic adv_s1, adv_s2, adv_s3, adv_out;
	assign adv_s1  = s_tvalid && rdy_s1;
	assign adv_s2  = v_s1 && rdy_s2;
	assign adv_s3  = v_s2 && rdy_s3;
	assign adv_out = v_s3 && rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1      <= s_tvalid;
			if (rdy_s2)  v_s2      <= v_s1;
			if (rdy_s3)  v_s3      <= v_s2;
			if (rdy_out) m_valid_q <= v_s3;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: input register. Bits above the sample width are dropped.
	// ---------------------------------------------------------------
	logic [SAMPLE_BITS-1:0] ref_s1, fb_s1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ref_s1 <= s_tdata[SAMPLE_BITS-1:0];
			fb_s1  <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: error, derivative and saturating integral.
	// error_sum_q and last_error_q double as this stage's operands: they
	// change exactly when a word enters the stage.
	// ---------------------------------------------------------------
	logic signed [SUM_W-1:0] error_sum_q;
	logic signed [ERR_W-1:0] last_error_q;
	logic signed [DEL_W-1:0] delta_s2;
	logic                    level_s2;

	logic signed [ERR_W-1:0] err;
	logic signed [DEL_W-1:0] delta;
	logic signed [SUM_W:0]   sum_ext;
	logic signed [SUM_W-1:0] sum_next;
	logic                    level;

	always_comb begin
		err     = $signed({2'b00, ref_s1[SAMPLE_BITS-1:1]}) - $signed({1'b0, fb_s1});
		delta   = $signed({err[ERR_W-1], err}) - $signed({last_error_q[ERR_W-1], last_error_q});
		sum_ext = $signed({error_sum_q[SUM_W-1], error_sum_q})
			+ $signed({{(SUM_W + 1 - ERR_W){err[ERR_W-1]}}, err});
		// clip at the signed 32-bit limits on overflow
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
			sum_next = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_next = sum_ext[SUM_W-1:0];
		end
		level = CMP_W'(ref_s1) >= CMP_W'(cfg.level_threshold);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else if (adv_s2) begin
			error_sum_q  <= sum_next;
			last_error_q <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			delta_s2 <= delta;
			level_s2 <= level;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: the three gain products, exact in Q.16.
	// ---------------------------------------------------------------
	logic signed [PP_W-1:0] prod_p_s3;
	logic signed [PI_W-1:0] prod_i_s3;
	logic signed [PD_W-1:0] prod_d_s3;
	logic                   level_s3;

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			prod_p_s3 <= $signed({1'b0, cfg.gain_p}) * last_error_q;
			prod_i_s3 <= $signed({1'b0, cfg.gain_i}) * error_sum_q;
			prod_d_s3 <= $signed({1'b0, cfg.gain_d}) * delta_s2;
			level_s3  <= level_s2;
		end
	end

	// ---------------------------------------------------------------
	// Output: sum, clamp to 0..ceiling, drop the fraction.
	// ---------------------------------------------------------------
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] top;
	logic [DUTY_W-1:0]       duty;
	logic [DUTY_W-1:0]       duty_q;
	logic                    level_q;

	always_comb begin
		acc = ACC_W'(prod_p_s3) + ACC_W'(prod_i_s3) + ACC_W'(prod_d_s3);
		top = $signed(ACC_W'({cfg.duty_ceiling, {FRAC{1'b0}}}));
		if (acc > top) begin
			duty = cfg.duty_ceiling;
		end else if (acc[ACC_W-1]) begin
			duty = '0;
		end else begin
			duty = acc[FRAC+DUTY_W-1:FRAC];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			duty_q  <= duty;
			level_q <= level_s3;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(pcd_pkg::OUT_W - DUTY_W - 1){1'b0}}, level_q, duty_q};

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_duty_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> duty_q <= cfg.duty_ceiling)
		else $error("duty above ceiling");

	a_state_held: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s2 |=> $stable(error_sum_q) && $stable(last_error_q))
		else $error("integral state moved without a word entering stage 2");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_tready && v_s3 && v_s2 && v_s1 |-> !s_tready)
		else $error("input accepted with every stage full and output stalled");

	a_out_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_out |=> m_valid_q)
		else $error("output word lost after stage 3 moved");

endmodule

[test/tb_top.sv]
// Self-checking bench for clamped_pid_duty_controller: sample words in, duty words out.
// Predicts every duty word with a mirror of the PID state and the registers.
// Depends on pcd_pkg and the RTL under sv/.
module tb_top;
	import pcd_pkg::*;

	localparam int IN_W        = ((2 * SAMPLE_BITS_DEF + 7) / 8) * 8;
	localparam int LATENCY     = 3;      // input accept to output valid with no stall
	localparam int HOLD_CYCLES = 64;     // long output stall, well past the pipeline depth
	localparam int QUIET_LIMIT = 2000;   // cycles with no word moving before we give up
	localparam int MAX_PRINT   = 100;    // mismatch lines printed before going quiet

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              level_high;
	} duty_word_t;

	// Mirror of the controller: registers, integral, previous error, and the
	// queue of duty words still owed by the block.
	class duty_scoreboard;
		pcd_cfg_t          cfg;
		logic signed [SUM_W-1:0]         integral;
		logic signed [SAMPLE_BITS_DEF:0] prev_err;
		duty_word_t        owed[$];
		int                words_in;
		int                words_out;
		int                mismatches;

		function new();
			cfg.gain_p          = GAIN_P_RST;
			cfg.gain_i          = GAIN_I_RST;
			cfg.gain_d          = GAIN_D_RST;
			cfg.duty_ceiling    = CEILING_RST;
			cfg.level_threshold = THRESHOLD_RST;
			integral   = '0;
			prev_err   = '0;
			words_in   = 0;
			words_out  = 0;
			mismatches = 0;
		endfunction

		// register write as the block sees it; unmapped indexes drop
		function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_GAIN_P:          cfg.gain_p = data[GAIN_W-1:0];
				REG_GAIN_I:          cfg.gain_i = data[GAIN_W-1:0];
				REG_GAIN_D:          cfg.gain_d = data[GAIN_W-1:0];
				REG_DUTY_CEILING:    cfg.duty_ceiling = data[DUTY_W-1:0];
				REG_LEVEL_THRESHOLD: cfg.level_threshold = data[THR_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// one accepted sample word -> one owed duty word
		function void note_sample(logic [IN_W-1:0] word);
			logic [SAMPLE_BITS_DEF-1:0]      ref_s;
			logic [SAMPLE_BITS_DEF-1:0]      fb_s;
			logic signed [SAMPLE_BITS_DEF:0]   err;
			logic signed [SAMPLE_BITS_DEF+1:0] delta;
			longint     wide_sum;
			longint     acc;
			longint     top;
			duty_word_t w;
			ref_s = word[SAMPLE_BITS_DEF-1:0];
			fb_s  = word[2*SAMPLE_BITS_DEF-1:SAMPLE_BITS_DEF];
			err   = $signed({2'b00, ref_s[SAMPLE_BITS_DEF-1:1]}) - $signed({1'b0, fb_s});
			delta = err - prev_err;
			// integral takes this error first, saturating at the 32-bit limits
			wide_sum = longint'(integral) + longint'(err);
			if (wide_sum > longint'(32'sh7FFF_FFFF))
				integral = 32'sh7FFF_FFFF;
			else if (wide_sum < -longint'(64'h8000_0000))
				integral = 32'sh8000_0000;
			else
				integral = wide_sum[SUM_W-1:0];
			acc = longint'(cfg.gain_p) * longint'(err)
				+ longint'(cfg.gain_i) * longint'(integral)
				+ longint'(cfg.gain_d) * longint'(delta);
			top = longint'(cfg.duty_ceiling) << FRAC_BITS;
			if (acc > top)
				w.duty = cfg.duty_ceiling;
			else if (acc < 0)
				w.duty = '0;
			else
				w.duty = DUTY_W'(acc >>> FRAC_BITS);   // fraction dropped
			w.level_high = (ref_s >= cfg.level_threshold);
			prev_err = err;
			owed.push_back(w);
			words_in++;
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			if (mismatches <= MAX_PRINT)
				$display("MISMATCH: %s", msg);
		endtask

		task check_word(logic [OUT_W-1:0] word);
			duty_word_t want;
			logic [DUTY_W-1:0] got_duty;
			logic              got_level;
			got_duty  = word[DUTY_W-1:0];
			got_level = word[DUTY_W];
			if (owed.size() == 0) begin
				report_mismatch($sformatf("duty word %0d arrived with nothing owed", words_out));
			end else begin
				want = owed.pop_front();
				if (got_duty !== want.duty)
					report_mismatch($sformatf("word %0d duty: got %0d, want %0d",
						words_out, got_duty, want.duty));
				if (got_level !== want.level_high)
					report_mismatch($sformatf("word %0d level_high: got %0b, want %0b",
						words_out, got_level, want.level_high));
			end
			words_out++;
		endtask
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata   = '0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [OUT_W-1:0]    m_tdata;
	logic                cfg_we    = 1'b0;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data  = '0;

	bit snd_idle_en = 1'b1;   // sender may drop tvalid now and then
	bit rcv_idle_en = 1'b1;   // receiver may drop tready now and then
	bit hold_req    = 1'b0;   // ask the receiver for one long stall
	int settings    = 0;
	int quiet       = 0;

	duty_scoreboard sb = new();

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	clamped_pid_duty_controller u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),    // reference_sample, feedback_sample, zero pad
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),    // duty, level_high, zero pad
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Handshake monitor. Reads at the edge see the values the DUT sampled,
	// since every driver here updates through NBAs.
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note_sample(s_tdata);
		if (m_tvalid && m_tready)
			sb.check_word(m_tdata);
	end

	// Watchdog: a stuck handshake or a lost word ends the run here.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("timeout: no word moved for %0d cycles, %0d duty words owed",
				QUIET_LIMIT, sb.pending());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver: random tready drops, plus one long hold when asked so the
	// pipeline fills and s_tready must fall.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= !(rcv_idle_en && $urandom_range(99) < 8);
			end
		end
	end

	// Offer one sample word; returns at the edge that accepts it, tvalid
	// still high so the next word can follow back to back.
	task automatic send_word(input logic [SAMPLE_BITS_DEF-1:0] ref_s,
			input logic [SAMPLE_BITS_DEF-1:0] fb_s);
		while (snd_idle_en && $urandom_range(99) < 8) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'({fb_s, ref_s});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Mostly feedback near the setpoint, steered so the integral stays
	// near zero and the duty lands inside its range; the rest is raw noise.
	task automatic send_random_sample();
		logic [SAMPLE_BITS_DEF-1:0] ref_s;
		logic [SAMPLE_BITS_DEF-1:0] fb_s;
		int err;
		int fb;
		ref_s = SAMPLE_BITS_DEF'($urandom);
		if ($urandom_range(99) < 15) begin
			fb_s = SAMPLE_BITS_DEF'($urandom);
		end else begin
			if (sb.integral < -2000)
				err = int'($urandom_range(60));
			else if (sb.integral > 2000)
				err = -int'($urandom_range(60));
			else
				err = int'($urandom_range(60)) - 30;
			fb = int'(ref_s >> 1) - err;
			if (fb < 0)
				fb = 0;
			if (fb > (1 << SAMPLE_BITS_DEF) - 1)
				fb = (1 << SAMPLE_BITS_DEF) - 1;
			fb_s = SAMPLE_BITS_DEF'(fb);
		end
		send_word(ref_s, fb_s);
	endtask

	// Drop tvalid, wait for every owed word, then let the pipe drain.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// Leaves cfg_we high; the caller lowers it after the last write.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic program_regs(input logic [CFG_W-1:0] gp, input logic [CFG_W-1:0] gi,
			input logic [CFG_W-1:0] gd, input logic [CFG_W-1:0] ceil_v,
			input logic [CFG_W-1:0] thr_v, input bit poke_unmapped);
		write_reg(REG_GAIN_P, gp);
		write_reg(REG_GAIN_I, gi);
		write_reg(REG_GAIN_D, gd);
		write_reg(REG_DUTY_CEILING, ceil_v);
		write_reg(REG_LEVEL_THRESHOLD, thr_v);
		// indexes past the map must leave every register alone
		if (poke_unmapped)
			for (int i = REG_LEVEL_THRESHOLD + 1; i < (1 << IDX_W); i++)
				write_reg(IDX_W'(i), CFG_W'($urandom));
		cfg_we <= 1'b0;
		settings++;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass on reset registers: gain 1.0, ~0.01, 0; ceiling 100.
		send_word(10'd0,    10'd0);      // zero error
		send_word(10'd1023, 10'd0);      // largest positive error, clamps to ceiling
		send_word(10'd0,    10'd1023);   // largest negative error, clamps to zero
		send_word(10'd1023, 10'd1023);
		send_word(10'd1,    10'd0);      // halving truncates to zero error
		send_word(10'd3,    10'd1);
		send_word(10'd621,  10'd300);    // just under the level threshold
		send_word(10'd622,  10'd300);    // on it
		send_word(10'd623,  10'd300);
		send_word(10'd1022, 10'd511);
		send_word(10'd600,  10'd250);
		send_word(10'd1023, 10'd0);      // pull the integral positive
		send_word(10'd1023, 10'd0);
		send_word(10'd1023, 10'd0);
		send_word(10'd400,  10'd190);    // in range, integral adds a fraction
		send_word(10'd400,  10'd210);
		send_word(10'd512,  10'd256);
		send_word(10'd1023, 10'd512);
		send_word(10'd256,  10'd0);
		send_word(10'd0,    10'd0);
		settle();

		// Full-scale P and D, no integral, widest ceiling, flag always set.
		program_regs(CFG_W'(24'hFF_FFFF), '0, CFG_W'(24'hFF_FFFF), CFG_W'(10'h3FF), '0, 1'b0);
		repeat (120) send_random_sample();
		settle();

		// All gains zero, zero ceiling, top threshold; also poke unmapped indexes.
		program_regs('0, '0, '0, '0, CFG_W'(10'h3FF), 1'b1);
		repeat (60) send_random_sample();
		settle();

		// Random settings. Ceiling gets a full 24-bit write so upper bits are
		// dropped. The integral limits need millions of words and stay out of reach.
		for (int k = 0; k < 6; k++) begin
			program_regs(
				(k == 5) ? CFG_W'($urandom) : CFG_W'($urandom_range(24'h04_0000)),
				(k == 5) ? CFG_W'($urandom) : CFG_W'($urandom_range(24'h00_2000)),
				(k == 5) ? CFG_W'($urandom) : CFG_W'($urandom_range(24'h04_0000)),
				CFG_W'($urandom), CFG_W'($urandom_range(1023)), k == 4);
			snd_idle_en = (k != 1);
			rcv_idle_en = (k != 1);
			if (k == 3)
				hold_req = 1'b1;
			repeat (120) send_random_sample();
			settle();
		end

		$display("covered %0d sample words, %0d duty words checked, %0d register settings",
			sb.words_in, sb.words_out, settings);
		$display("incl. zero/full-scale gains, zero ceiling, unmapped writes, %0d-cycle stall",
			HOLD_CYCLES);
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
